@@ hdl/gsp_pkg.sv @@
// Shared types, constants and helper functions for the gamepad serial port.
// No dependencies; imported by every module of the block.
package gsp_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_MASK   = 2'd1,
    ACT_STROBE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  localparam int NUM_PLAYERS = 4;
  localparam int NUM_PORTS   = 2;
  localparam int BTN_W       = 8;
  localparam int LATCH_W     = 20;
  localparam int SHIFT_W     = 32;
  localparam int SIG_W       = 4;

  localparam logic [SIG_W-1:0] SIG_PORT0 = 4'h8;
  localparam logic [SIG_W-1:0] SIG_PORT1 = 4'h4;

  localparam logic [BTN_W-1:0] UD_MASK   = 8'h30;
  localparam logic [BTN_W-1:0] LR_MASK   = 8'hC0;
  localparam logic [BTN_W-1:0] READ_BASE = 8'h40;

  localparam logic [SHIFT_W-1:0] FILL_LOW = 32'h0000_0080;
  localparam logic [SHIFT_W-1:0] FILL_TOP = 32'h8000_0000;

  // One input item as it travels through the block
  typedef struct packed {
    action_t          action;
    logic [1:0]       player;
    logic             port;
    logic [BTN_W-1:0] button_value;
    logic             pressed;
  } cmd_t;

  // Opposite directions held together cancel in the safe copy
  function automatic logic [BTN_W-1:0] safe_copy(input logic [BTN_W-1:0] raw);
    logic [BTN_W-1:0] s;
    s = raw;
    if ((s & UD_MASK) == UD_MASK) s = s & ~UD_MASK;
    if ((s & LR_MASK) == LR_MASK) s = s & ~LR_MASK;
    return s;
  endfunction

endpackage

@@ hdl/gamepad_serial_port.sv @@
// Top level of the gamepad serial port: input register, core state, result register.
// Depends on gsp_pkg, gsp_button_file and gsp_serial_shift.
//
// Four-player serial controller port on two ports. Each item (button set,
// button press/release, strobe write, port read) is taken into an input
// register and handled from there; one item per clock is sustained while
// no read stalls. A port read produces one result, 0x40 with the serial
// data bit in bit 0, which is loaded into the output register when the read
// is handled; other actions produce no result. The input side stalls only when
// a read is waiting in the input register and the output register still holds
// a result that has not been taken. cfg_wr_data selects where the one fill
// bit enters the shift word after a read: 0 at bit 7, 1 at bit 31.
module gamepad_serial_port (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [1:0]                in_player,
  input  logic                      in_port,
  input  logic [7:0]                in_button_value,
  input  logic                      in_pressed,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_read_data
);
  import gsp_pkg::*;

  logic                              in_valid_r;
  cmd_t                              cmd_r;
  logic                              out_valid_r;
  logic [BTN_W-1:0]                  read_data_r;

  logic                              cmd_fire;
  logic                              is_read;
  logic [NUM_PORTS-1:0][LATCH_W-1:0] latch_word;
  logic [BTN_W-1:0]                  read_data;

  // Reads need a free result slot; other actions always proceed
  assign is_read  = (cmd_r.action == ACT_READ);
  assign cmd_fire = in_valid_r && (!is_read || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || cmd_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.action       <= action_t'(in_action);
      cmd_r.player       <= in_player;
      cmd_r.port         <= in_port;
      cmd_r.button_value <= in_button_value;
      cmd_r.pressed      <= in_pressed;
    end
  end

  gsp_button_file u_button_file (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_fire   (cmd_fire),
    .cmd        (cmd_r),
    .latch_word (latch_word)
  );

  gsp_serial_shift u_serial_shift (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_fire    (cmd_fire),
    .cmd         (cmd_r),
    .latch_word  (latch_word),
    .read_data   (read_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_fire && is_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && is_read) begin
      read_data_r <= read_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = read_data_r;

endmodule

@@ hdl/gsp_button_file.sv @@
// Per-player raw and safe button bytes, plus the two port latch words.
// Depends on gsp_pkg.
module gsp_button_file (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cmd_fire,
  input  gsp_pkg::cmd_t                            cmd,
  output logic [gsp_pkg::NUM_PORTS-1:0][gsp_pkg::LATCH_W-1:0] latch_word
);
  import gsp_pkg::*;

  logic [BTN_W-1:0]   raw_r   [NUM_PLAYERS];
  logic [BTN_W-1:0]   safe_r  [NUM_PLAYERS];
  logic [LATCH_W-1:0] latch_r [NUM_PORTS];

  logic [BTN_W-1:0]   raw_cur;
  logic [BTN_W-1:0]   raw_nxt;
  logic [BTN_W-1:0]   safe_nxt;
  logic [LATCH_W-1:0] latch_cur;
  logic [LATCH_W-1:0] latch_nxt;
  logic [SIG_W-1:0]   sig;
  logic               btn_upd;
  logic               safe_changed;

  // New raw byte for a set or press/release
  always_comb begin
    raw_cur = raw_r[cmd.player];
    case (cmd.action)
      ACT_SET:  raw_nxt = cmd.button_value;
      ACT_MASK: raw_nxt = cmd.pressed ? (raw_cur | cmd.button_value)
                                      : (raw_cur & ~cmd.button_value);
      default:  raw_nxt = raw_cur;
    endcase
  end

  assign btn_upd      = cmd_fire && (cmd.action == ACT_SET || cmd.action == ACT_MASK);
  assign safe_nxt     = safe_copy(raw_nxt);
  assign safe_changed = (safe_nxt != safe_r[cmd.player]);

  // Players 0/1 sit in the low byte, 2/3 in the high byte, signature on top
  always_comb begin
    latch_cur = latch_r[cmd.player[0]];
    sig       = cmd.player[0] ? SIG_PORT1 : SIG_PORT0;
    if (!cmd.player[1]) begin
      latch_nxt = {sig, latch_cur[2*BTN_W-1:BTN_W], safe_nxt};
    end else begin
      latch_nxt = {sig, safe_nxt, latch_cur[BTN_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLAYERS; i++) begin
        raw_r[i]  <= '0;
        safe_r[i] <= '0;
      end
      for (int j = 0; j < NUM_PORTS; j++) begin
        latch_r[j] <= '0;
      end
    end else if (btn_upd) begin
      raw_r[cmd.player]  <= raw_nxt;
      safe_r[cmd.player] <= safe_nxt;
      if (safe_changed) begin
        latch_r[cmd.player[0]] <= latch_nxt;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PORTS; k++) begin
      latch_word[k] = latch_r[k];
    end
  end

endmodule

@@ hdl/gsp_serial_shift.sv @@
// Strobe level, fill mode register and the two port shift words; forms read data.
// Depends on gsp_pkg.
module gsp_serial_shift (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic                                     cfg_wr_data,
  input  logic                                     cmd_fire,
  input  gsp_pkg::cmd_t                            cmd,
  input  logic [gsp_pkg::NUM_PORTS-1:0][gsp_pkg::LATCH_W-1:0] latch_word,
  output logic [gsp_pkg::BTN_W-1:0]                read_data
);
  import gsp_pkg::*;

  logic               mode_r;
  logic               strobe_r;
  logic [SHIFT_W-1:0] shift_r [NUM_PORTS];

  logic               strobe_nxt;
  logic               strobe_fall;
  logic               read_shift;
  logic               data_bit;
  logic [SHIFT_W-1:0] fill;
  logic [SHIFT_W-1:0] shift_cur;
  logic [SHIFT_W-1:0] shift_nxt;

  assign strobe_nxt  = cmd.button_value[0];
  assign strobe_fall = cmd_fire && (cmd.action == ACT_STROBE) && strobe_r && !strobe_nxt;
  assign read_shift  = cmd_fire && (cmd.action == ACT_READ) && !strobe_r;

  // Serial bit: latch while strobe is high, shift word otherwise
  assign shift_cur = shift_r[cmd.port];
  assign data_bit  = strobe_r ? latch_word[cmd.port][0] : shift_cur[0];
  assign read_data = READ_BASE | {{(BTN_W-1){1'b0}}, data_bit};

  assign fill      = mode_r ? FILL_TOP : FILL_LOW;
  assign shift_nxt = fill | (shift_cur >> 1);

  // Fill mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Strobe level and shift words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        shift_r[i] <= '0;
      end
    end else begin
      if (cmd_fire && cmd.action == ACT_STROBE) begin
        strobe_r <= strobe_nxt;
      end
      if (strobe_fall) begin
        for (int i = 0; i < NUM_PORTS; i++) begin
          shift_r[i] <= {{(SHIFT_W-LATCH_W){1'b0}}, latch_word[i]};
        end
      end else if (read_shift) begin
        shift_r[cmd.port] <= shift_nxt;
      end
    end
  end

endmodule
